>>> src/dqe_pkg.sv
`timescale 1ns / 1ps

package dqe_pkg;

    localparam int MAX_NAME_BYTES_DEF = 256;
    localparam logic [15:0] QUERY_PORT_RESET = 16'd53;
    localparam int QUESTION_TAIL = 5;
    localparam logic [7:0] UDP_PROTO = 8'd17;
    localparam int NAME_START = 54;
    localparam int QUEUE_DEPTH = 4;

    localparam logic ITEM_NAME = 1'b0;
    localparam logic ITEM_SUMMARY = 1'b1;

    localparam logic [1:0] VERDICT_DROP = 2'd0;
    localparam logic [1:0] VERDICT_PASS = 2'd1;
    localparam logic [1:0] VERDICT_EXTRACTED = 2'd2;

    // One classified input byte: an optional name byte and an optional summary
    typedef struct packed {
        logic        has_name;
        logic [7:0]  name_byte;
        logic        has_summary;
        logic [1:0]  verdict;
        logic [31:0] source_address;
        logic [7:0]  name_length;
        logic [15:0] query_type;
        logic [15:0] query_class;
    } work_entry_t;

endpackage

>>> src/dqe_front.sv
`timescale 1ns / 1ps

module dqe_front #(
    parameter int MAX_NAME_BYTES = dqe_pkg::MAX_NAME_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [7:0]           frame_byte,
    input  logic                 frame_last,
    input  logic                 cfg_valid,
    input  logic [15:0]          cfg_data,
    output logic                 q_push,
    output dqe_pkg::work_entry_t q_entry
);

    localparam int NPW = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;
    localparam logic [NPW-1:0] NP_LAST = NPW'(MAX_NAME_BYTES - 1);

    // position only matters up to the question start, so it saturates early
    localparam int POS_W = 6;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_PROTO = POS_W'(23);
    localparam logic [POS_W-1:0] POS_SRC_LO = POS_W'(26);
    localparam logic [POS_W-1:0] POS_SRC_HI = POS_W'(29);
    localparam logic [POS_W-1:0] POS_PORT_HI = POS_W'(36);
    localparam logic [POS_W-1:0] POS_PORT_LO = POS_W'(37);
    localparam logic [POS_W-1:0] POS_FLAGS = POS_W'(44);
    localparam logic [POS_W-1:0] POS_NAME = POS_W'(dqe_pkg::NAME_START);
    // last byte index below these means the frame is shorter than 34/42/54
    localparam logic [POS_W-1:0] POS_SHORT_IP = POS_W'(33);
    localparam logic [POS_W-1:0] POS_SHORT_UDP = POS_W'(41);
    localparam logic [POS_W-1:0] POS_SHORT_DNS = POS_W'(dqe_pkg::NAME_START - 1);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_NAME = 3'd1;
    localparam logic [2:0] PH_TAIL0 = 3'd2;
    localparam logic [2:0] PH_DONE = 3'(2 + dqe_pkg::QUESTION_TAIL - 1);
    localparam logic [2:0] PH_LONG = 3'd7;

    logic [15:0]      match_port_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       proto_reg, proto_next;
    logic [31:0]      src_reg, src_next;
    logic [15:0]      port_reg, port_next;
    logic             resp_reg, resp_next;
    logic [2:0]       phase_reg, phase_next;
    logic [NPW-1:0]   npos_reg, npos_next;
    logic [31:0]      tc_reg, tc_next;

    logic             accept;
    logic [2:0]       phase_eff;
    logic             is_query;
    logic             emit;
    logic [1:0]       verdict;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        proto_next = (pos_reg == POS_PROTO) ? frame_byte : proto_reg;
        src_next = (pos_reg inside {[POS_SRC_LO:POS_SRC_HI]}) ? {src_reg[23:0], frame_byte}
                                                                : src_reg;
        port_next = (pos_reg == POS_PORT_HI || pos_reg == POS_PORT_LO)
                    ? {port_reg[7:0], frame_byte} : port_reg;
        resp_next = (pos_reg == POS_FLAGS) ? frame_byte[7] : resp_reg;
        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

        phase_eff = (phase_reg == PH_HEADER && pos_reg == POS_NAME) ? PH_NAME : phase_reg;
        is_query = (proto_next == dqe_pkg::UDP_PROTO) && (port_next == match_port_reg)
                   && !resp_next;

        phase_next = phase_eff;
        npos_next = npos_reg;
        tc_next = tc_reg;
        emit = 1'b0;
        if (phase_eff == PH_NAME)
        begin
            if (frame_byte == 8'd0)
            begin
                phase_next = PH_TAIL0;
            end
            else
            begin
                emit = is_query;
                if (npos_reg == NP_LAST)
                    phase_next = PH_LONG;
                else
                    npos_next = npos_reg + 1'b1;
            end
        end
        else if (phase_eff >= PH_TAIL0 && phase_eff < PH_DONE)
        begin
            tc_next = {tc_reg[23:0], frame_byte};
            phase_next = phase_eff + 3'd1;
        end

        if (pos_reg < POS_SHORT_IP)
            verdict = dqe_pkg::VERDICT_DROP;
        else if (proto_next != dqe_pkg::UDP_PROTO)
            verdict = dqe_pkg::VERDICT_PASS;
        else if (pos_reg < POS_SHORT_UDP)
            verdict = dqe_pkg::VERDICT_DROP;
        else if (port_next != match_port_reg)
            verdict = dqe_pkg::VERDICT_PASS;
        else if (pos_reg < POS_SHORT_DNS)
            verdict = dqe_pkg::VERDICT_DROP;
        else if (resp_next)
            verdict = dqe_pkg::VERDICT_PASS;
        else if (phase_next == PH_DONE)
            verdict = dqe_pkg::VERDICT_EXTRACTED;
        else
            verdict = dqe_pkg::VERDICT_DROP;

        q_entry = '0;
        q_entry.has_name = emit;
        q_entry.name_byte = frame_byte;
        q_entry.has_summary = frame_last;
        q_entry.verdict = verdict;
        if (verdict == dqe_pkg::VERDICT_EXTRACTED)
        begin
            q_entry.source_address = src_next;
            q_entry.name_length = 8'(npos_next);
            q_entry.query_type = tc_next[31:16];
            q_entry.query_class = tc_next[15:0];
        end
    end

    assign q_push = accept && (emit || frame_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_port_reg <= dqe_pkg::QUERY_PORT_RESET;
        end
        else if (cfg_valid)
        begin
            match_port_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            proto_reg <= '0;
            src_reg <= '0;
            port_reg <= '0;
            resp_reg <= 1'b0;
            phase_reg <= PH_HEADER;
            npos_reg <= '0;
            tc_reg <= '0;
        end
        else if (accept)
        begin
            if (frame_last)
            begin
                pos_reg <= '0;
                proto_reg <= '0;
                src_reg <= '0;
                port_reg <= '0;
                resp_reg <= 1'b0;
                phase_reg <= PH_HEADER;
                npos_reg <= '0;
                tc_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                proto_reg <= proto_next;
                src_reg <= src_next;
                port_reg <= port_next;
                resp_reg <= resp_next;
                phase_reg <= phase_next;
                npos_reg <= npos_next;
                tc_reg <= tc_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_last |=> pos_reg == '0 && phase_reg == PH_HEADER)
        else $error("frame state not cleared after last byte");
`endif

endmodule

>>> src/dqe_queue.sv
`timescale 1ns / 1ps

module dqe_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dqe_pkg::work_entry_t push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output dqe_pkg::work_entry_t head
);

    localparam int DEPTH = dqe_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dqe_pkg::work_entry_t entry_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head = entry_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");
`endif

endmodule

>>> src/dqe_back.sv
`timescale 1ns / 1ps

module dqe_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  dqe_pkg::work_entry_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 item_kind,
    output logic [7:0]           name_byte,
    output logic [1:0]           verdict,
    output logic [31:0]          source_address,
    output logic [7:0]           name_length,
    output logic [15:0]          query_type,
    output logic [15:0]          query_class,
    output logic                 last_of_run
);

    logic        out_valid_reg, out_valid_next;
    logic        name_done_reg, name_done_next;
    logic        kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic [1:0]  verdict_reg, verdict_next;
    logic [31:0] src_reg, src_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] class_reg, class_next;
    logic        last_reg, last_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        name_done_next = name_done_reg;
        kind_next = kind_reg;
        byte_next = byte_reg;
        verdict_next = verdict_reg;
        src_next = src_reg;
        len_next = len_reg;
        type_next = type_reg;
        class_next = class_reg;
        last_next = last_reg;
        pop = 1'b0;

        if (slot_free)
            out_valid_next = 1'b0;

        if (slot_free && head_valid)
        begin
            out_valid_next = 1'b1;
            if (head.has_name && !name_done_reg)
            begin
                kind_next = dqe_pkg::ITEM_NAME;
                byte_next = head.name_byte;
                verdict_next = dqe_pkg::VERDICT_DROP;
                src_next = '0;
                len_next = '0;
                type_next = '0;
                class_next = '0;
                last_next = !head.has_summary;
                // summary of the same byte follows before the entry is released
                if (head.has_summary)
                    name_done_next = 1'b1;
                else
                    pop = 1'b1;
            end
            else
            begin
                kind_next = dqe_pkg::ITEM_SUMMARY;
                byte_next = '0;
                verdict_next = head.verdict;
                src_next = head.source_address;
                len_next = head.name_length;
                type_next = head.query_type;
                class_next = head.query_class;
                last_next = 1'b1;
                name_done_next = 1'b0;
                pop = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            name_done_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            name_done_reg <= name_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        verdict_reg <= verdict_next;
        src_reg <= src_next;
        len_reg <= len_next;
        type_reg <= type_next;
        class_reg <= class_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign item_kind = kind_reg;
    assign name_byte = byte_reg;
    assign verdict = verdict_reg;
    assign source_address = src_reg;
    assign name_length = len_reg;
    assign query_type = type_reg;
    assign query_class = class_reg;
    assign last_of_run = last_reg;

`ifndef SYNTHESIS
    a_summary_follows_name: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && item_kind == dqe_pkg::ITEM_NAME && !last_of_run
        |=> out_valid && item_kind == dqe_pkg::ITEM_SUMMARY)
        else $error("summary did not follow a non-final name item");
`endif

endmodule

>>> src/dns_query_extract.sv
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------------
// input    | in_valid / in_ready  | frame_byte, frame_last
// output   | out_valid / out_ready| item_kind, name_byte, verdict, source_address,
//          |                      | name_length, query_type, query_class, last_of_run
// config   | cfg_valid / cfg_ready| cfg_data (DNS port)
//
// One frame byte is taken per cycle while in_ready is high; the front classifies it
// in that cycle. Results leave through a registered output, one per cycle while out_ready
// is high; a last byte that also carries a name byte gives two results and holds its queue
// entry until the second is issued. Each result passes the queue, then the output register.
// Reset clears the parse state and the queue and sets the DNS port to 53; no clearing pass.
// in_ready drops only when the four-entry queue is full; cfg_ready is always high.

module dns_query_extract #(
    parameter int MAX_NAME_BYTES = dqe_pkg::MAX_NAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  frame_byte,
    input  logic        frame_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        item_kind,
    output logic [7:0]  name_byte,
    output logic [1:0]  verdict,
    output logic [31:0] source_address,
    output logic [7:0]  name_length,
    output logic [15:0] query_type,
    output logic [15:0] query_class,
    output logic        last_of_run
);

    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_head_valid;
    dqe_pkg::work_entry_t q_push_entry;
    dqe_pkg::work_entry_t q_head;

    assign in_ready = !q_full;
    assign cfg_ready = 1'b1;

    dqe_front #(
        .MAX_NAME_BYTES(MAX_NAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .frame_byte(frame_byte),
        .frame_last(frame_last),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_entry   (q_push_entry)
    );

    dqe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_entry(q_push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_head_valid),
        .head      (q_head)
    );

    dqe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_head_valid),
        .head          (q_head),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .item_kind     (item_kind),
        .name_byte     (name_byte),
        .verdict       (verdict),
        .source_address(source_address),
        .name_length   (name_length),
        .query_type    (query_type),
        .query_class   (query_class),
        .last_of_run   (last_of_run)
    );

endmodule
